/* design/assert_macros.svh */
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication check, reset aware
`define ASSERT_IMPL(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) cond) else $error("%m failed");
`endif

/* design/spd_pkg.sv */
// Package: constants and types of the shortest path solver
package spd_pkg;
    localparam int MAX_NODES = 64;
    localparam int NODE_W = $clog2(MAX_NODES);
    localparam int CNT_W = NODE_W + 1;
    localparam int ADDR_W = 2 * NODE_W;
    localparam int DIST_W = 13;
    localparam logic [DIST_W-1:0] NO_EDGE = DIST_W'(5000);
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_NODE = 1'b1;
    localparam logic FUNC_ADD = 1'b0;
    localparam logic FUNC_SOLVE = 1'b1;

    // Commands from controller to datapath
    typedef struct packed {
        logic              clr_we;      // write NO_EDGE at clr address
        logic              edge_rd;     // read entry a,b
        logic              edge_wr;     // write min at a,b; read entry b,a
        logic              edge_wr_rev; // write min at b,a
        logic              init;        // init distance/visited at idx
        logic              scan;        // read entry idx for the min search
        logic              scan_clear;  // restart min search
        logic              mark;        // mark picked node visited
        logic              rel_rd;      // read matrix row entry idx
        logic              rel_upd;     // relax with last read entry
        logic [ADDR_W-1:0] clr_addr;
        logic [NODE_W-1:0] idx;
        logic [NODE_W-1:0] src;
        logic              src_ok;
    } spd_cmd_t;

    typedef struct packed {
        logic              found;
        logic [DIST_W-1:0] out_dist;
    } spd_stat_t;
endpackage

/* design/spd_datapath.sv */
// Datapath: weight matrix, distance store, min search and relaxation
module spd_datapath (
    input  logic                       clk,
    input  spd_pkg::spd_cmd_t          cmd,
    input  logic [spd_pkg::NODE_W-1:0] a,
    input  logic [spd_pkg::NODE_W-1:0] b,
    input  logic [spd_pkg::DIST_W-1:0] w,
    output spd_pkg::spd_stat_t         stat
);
    import spd_pkg::*;

    logic [DIST_W-1:0] wmat     [MAX_NODES*MAX_NODES];
    logic [DIST_W-1:0] dist_mem [MAX_NODES];
    logic              vis_mem  [MAX_NODES];
    logic [DIST_W-1:0] rd_w_reg, rd_dist_reg;
    logic              rd_vis_reg;
    logic [NODE_W-1:0] idx_d_reg;
    logic              scan_d_reg;
    logic [DIST_W-1:0] least_reg, wsat, wr_data;
    logic [NODE_W-1:0] u_reg;
    logic              found_reg;
    logic [DIST_W:0]   sum;
    logic [ADDR_W-1:0] rd_addr, wr_addr;
    logic              rd_en, wr_en;
    logic              dwr_en, vwr_en;
    logic [NODE_W-1:0] dwr_addr, vwr_addr;
    logic [DIST_W-1:0] dwr_data;

    assign wsat = (w > NO_EDGE) ? NO_EDGE : w;
    assign sum  = {1'b0, least_reg} + {1'b0, rd_w_reg};

    // Select the single matrix read and write address
    assign rd_en   = cmd.edge_rd | cmd.edge_wr | cmd.rel_rd;
    assign rd_addr = cmd.edge_rd ? {a, b} : (cmd.edge_wr ? {b, a} : {u_reg, cmd.idx});
    assign wr_en   = cmd.clr_we | ((cmd.edge_wr | cmd.edge_wr_rev) & (wsat < rd_w_reg));
    assign wr_addr = cmd.clr_we ? cmd.clr_addr : (cmd.edge_wr ? {a, b} : {b, a});
    assign wr_data = cmd.clr_we ? NO_EDGE : wsat;

    // Matrix port: one write, one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en) wmat[wr_addr] <= wr_data;
        if (rd_en) rd_w_reg <= wmat[rd_addr];
    end

    // Select the single distance and visited write
    assign dwr_en   = cmd.init |
                      (cmd.rel_upd && rd_w_reg < NO_EDGE && sum < {1'b0, rd_dist_reg});
    assign dwr_addr = cmd.init ? cmd.idx : idx_d_reg;
    assign dwr_data = cmd.init ? ((cmd.src_ok && cmd.idx == cmd.src) ? '0 : NO_EDGE) :
                      sum[DIST_W-1:0];
    assign vwr_en   = cmd.init | cmd.mark;
    assign vwr_addr = cmd.init ? cmd.idx : u_reg;

    // Distance store and visited flags, read registered at idx
    always_ff @(posedge clk)
    begin
        rd_dist_reg <= dist_mem[cmd.idx];
        rd_vis_reg  <= vis_mem[cmd.idx];
        idx_d_reg   <= cmd.idx;
        scan_d_reg  <= cmd.scan;
        if (dwr_en) dist_mem[dwr_addr] <= dwr_data;
        if (vwr_en) vis_mem[vwr_addr] <= ~cmd.init;
    end

    // Track the least unvisited distance, one entry behind the read
    always_ff @(posedge clk)
    begin
        if (cmd.scan_clear) begin
            least_reg <= NO_EDGE;
            found_reg <= 1'b0;
        end
        if (scan_d_reg && !rd_vis_reg && rd_dist_reg < least_reg) begin
            least_reg <= rd_dist_reg;
            u_reg     <= idx_d_reg;
            found_reg <= 1'b1;
        end
    end

    assign stat.found    = found_reg;
    assign stat.out_dist = rd_dist_reg;
endmodule

/* design/spd_ctrl.sv */
// Controller: sequencing of clear, edge add, solve and result output
module spd_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic                       func,
    input  logic [spd_pkg::CNT_W-1:0]  n_eff,
    input  logic [spd_pkg::NODE_W-1:0] src,
    input  logic                       src_ok,
    input  spd_pkg::spd_stat_t         stat,
    output spd_pkg::spd_cmd_t          cmd,
    output logic                       busy,
    output logic                       result_valid,
    output logic [spd_pkg::NODE_W-1:0] res_idx,
    output logic                       res_last
);
    import spd_pkg::*;

    localparam logic [3:0] S_CLR = 4'd0, S_IDLE = 4'd1, S_E1 = 4'd2, S_E2 = 4'd3,
                           S_E3 = 4'd4, S_INIT = 4'd5, S_SCAN = 4'd6, S_PICK = 4'd7,
                           S_REL = 4'd8, S_RELL = 4'd9, S_OUT = 4'd10, S_OUTE = 4'd11,
                           S_SCANL = 4'd12;

    logic [3:0]        state_reg, state_next;
    logic [ADDR_W-1:0] clr_reg, clr_next;
    logic [CNT_W-1:0]  i_reg, i_next, n_reg, n_next;
    logic              last_step;
    logic              out_v_reg, out_v_next, out_l_reg, out_l_next;
    logic [NODE_W-1:0] out_i_reg, out_i_next;

    assign last_step = (i_reg + 1'b1 == n_reg);

    // Hold state and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= S_CLR;
            clr_reg   <= '0;
            i_reg     <= '0;
            n_reg     <= '0;
            out_v_reg <= 1'b0;
            out_l_reg <= 1'b0;
            out_i_reg <= '0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            i_reg     <= i_next;
            n_reg     <= n_next;
            out_v_reg <= out_v_next;
            out_l_reg <= out_l_next;
            out_i_reg <= out_i_next;
        end
    end

    // Advance the sequence
    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        i_next     = i_reg;
        n_next     = n_reg;
        out_v_next = 1'b0;
        out_l_next = 1'b0;
        out_i_next = out_i_reg;
        cmd        = '0;
        cmd.clr_addr = clr_reg;
        cmd.idx    = i_reg[NODE_W-1:0];
        cmd.src    = src;
        cmd.src_ok = src_ok;
        unique case (state_reg)
            S_CLR: begin
                cmd.clr_we = 1'b1;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == '1) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (start) begin
                    i_next = '0;
                    n_next = n_eff;
                    if (func == FUNC_ADD) state_next = S_E1;
                    else state_next = S_INIT;
                end
            end
            S_E1: begin
                cmd.edge_rd = 1'b1;
                state_next = S_E2;
            end
            S_E2: begin
                cmd.edge_wr = 1'b1;
                state_next = S_E3;
            end
            S_E3: begin
                cmd.edge_wr_rev = 1'b1;
                state_next = S_IDLE;
            end
            S_INIT: begin
                cmd.init = 1'b1;
                i_next = i_reg + 1'b1;
                if (last_step) begin
                    i_next = '0;
                    cmd.scan_clear = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                cmd.scan = 1'b1;
                i_next = i_reg + 1'b1;
                if (last_step) begin
                    i_next = '0;
                    state_next = S_SCANL;
                end
            end
            S_SCANL: state_next = S_PICK;
            S_PICK: begin
                if (stat.found) begin
                    cmd.mark = 1'b1;
                    state_next = S_REL;
                end else state_next = S_OUT;
            end
            S_REL: begin
                cmd.rel_rd = 1'b1;
                if (i_reg != '0) cmd.rel_upd = 1'b1;
                i_next = i_reg + 1'b1;
                if (last_step) state_next = S_RELL;
            end
            S_RELL: begin
                cmd.rel_upd = 1'b1;
                cmd.scan_clear = 1'b1;
                i_next = '0;
                state_next = S_SCAN;
            end
            S_OUT: begin
                out_v_next = 1'b1;
                out_i_next = i_reg[NODE_W-1:0];
                out_l_next = last_step;
                i_next = i_reg + 1'b1;
                if (last_step) state_next = S_OUTE;
            end
            S_OUTE: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    assign busy         = (state_reg != S_IDLE);
    assign result_valid = out_v_reg;
    assign res_idx      = out_i_reg;
    assign res_last     = out_l_reg;
endmodule

/* design/shortest_path_dijkstra_solver.sv */
// Top level: Dijkstra shortest path solver with edge loading
// After reset a clearing pass writes no-edge to all 4096 matrix entries; busy is high.
// An edge add reads entry a,b, then writes the weight at a,b and at b,a where lighter.
// A solve over n nodes scans the distances one entry per cycle and relaxes each reached
// node's row one entry per cycle; results stream one per cycle at the end of the solve.
// The receiver cannot stall. Reset: node_count 64, source_node 0.
module shortest_path_dijkstra_solver (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          func,
    input  logic [5:0]                    node_a,
    input  logic [5:0]                    node_b,
    input  logic [12:0]                   edge_weight,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [spd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [6:0]                    cfg_data,
    output logic                          result_valid,
    output logic [5:0]                    node_index,
    output logic [12:0]                   distance,
    output logic                          last
);
    import spd_pkg::*;

    logic [6:0]        node_count_reg;
    logic [5:0]        source_node_reg;
    logic [CNT_W-1:0]  n_eff;
    logic [NODE_W-1:0] a_reg, b_reg;
    logic [DIST_W-1:0] w_reg;
    logic              src_ok;
    spd_cmd_t          cmd;
    spd_stat_t         stat;

    assign cfg_ready = 1'b1;

    // Hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            node_count_reg  <= 7'd64;
            source_node_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_NODE_COUNT:  node_count_reg  <= cfg_data;
                REG_SOURCE_NODE: source_node_reg <= cfg_data[5:0];
                default: ;
            endcase
        end
    end

    // Capture the input word
    always_ff @(posedge clk)
    begin
        if (start && !busy) begin
            a_reg <= node_a;
            b_reg <= node_b;
            w_reg <= edge_weight;
        end
    end

    assign n_eff = (node_count_reg == '0) ? CNT_W'(1) :
                   (node_count_reg > 7'(MAX_NODES)) ? CNT_W'(MAX_NODES) :
                   node_count_reg[CNT_W-1:0];
    assign src_ok = ({1'b0, source_node_reg} < node_count_reg) && (node_count_reg != '0)
                    || (node_count_reg == '0 && source_node_reg == '0);

    spd_ctrl u_ctrl (
        .clk, .rst_n, .start, .func, .n_eff,
        .src(source_node_reg), .src_ok, .stat, .cmd, .busy,
        .result_valid, .res_idx(node_index), .res_last(last)
    );

    spd_datapath u_dp (
        .clk, .cmd, .a(a_reg), .b(b_reg), .w(w_reg), .stat
    );

    assign distance = stat.out_dist;
endmodule

/* design/spd_checker.sv */
// Checker on the solver ports, bound to the top level
`include "assert_macros.svh"
module spd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        busy,
    input logic        result_valid,
    input logic        last,
    input logic [12:0] distance
);
    `ASSERT_IMPL(a_res_busy, clk, rst_n, result_valid |-> busy)
    `ASSERT_IMPL(a_dist_rng, clk, rst_n, result_valid |-> distance <= 13'd5000)
    `ASSERT_IMPL(a_last_end, clk, rst_n, (result_valid && last) |=> !result_valid)
endmodule

bind shortest_path_dijkstra_solver spd_checker u_chk (
    .clk, .rst_n, .busy, .result_valid, .last, .distance
);

/* verif/tb_shortest_path_dijkstra_solver.sv */
// Testbench for the shortest path solver: edge loading, solves and distance checks
`timescale 1ns / 1ps

module tb_shortest_path_dijkstra_solver;
    import spd_pkg::*;

    localparam int WATCHDOG_LIMIT = 60000;
    localparam int MAX_N = 64;

    typedef struct {
        logic [5:0]  node;
        logic [12:0] dval;
        logic        fin;
    } dist_word_t;

    // Distance predictor: own weight matrix, registers and pending distance words
    class dist_tracker;
        logic [12:0] weights[MAX_N][MAX_N];
        logic [6:0]  node_count;
        logic [5:0]  source_node;
        dist_word_t  pending_dist[$];

        function new();
            foreach (weights[i, j]) weights[i][j] = 13'd5000;
            node_count  = 7'd64;
            source_node = 6'd0;
        endfunction

        function void note_reg(logic [CFG_IDX_W-1:0] idx, logic [6:0] data);
            if (idx == REG_NODE_COUNT) node_count = data;
            else source_node = data[5:0];
        endfunction

        function void note_item(logic fn, logic [5:0] a, logic [5:0] b, logic [12:0] w);
            int n;
            int least;
            int u;
            int sum;
            bit found;
            int dist_now[MAX_N];
            bit seen[MAX_N];
            dist_word_t word;
            if (fn == FUNC_ADD) begin
                // saturate heavy weights to no-edge, keep the lighter parallel edge
                if (w > 13'd5000) w = 13'd5000;
                if (w < weights[a][b]) weights[a][b] = w;
                if (w < weights[b][a]) weights[b][a] = w;
                return;
            end
            n = (node_count == 0) ? 1 : ((node_count > MAX_N) ? MAX_N : node_count);
            for (int i = 0; i < n; i++) begin
                dist_now[i] = 5000;
                seen[i] = 0;
            end
            if (source_node < n) dist_now[source_node] = 0;
            // pick lowest unvisited below no-edge, relax its row
            forever begin
                least = 5000;
                u = 0;
                found = 0;
                for (int i = 0; i < n; i++)
                    if (!seen[i] && dist_now[i] < least) begin
                        least = dist_now[i];
                        u = i;
                        found = 1;
                    end
                if (!found) break;
                seen[u] = 1;
                for (int i = 0; i < n; i++) begin
                    if (weights[u][i] >= 13'd5000) continue;
                    sum = least + weights[u][i];
                    if (sum < dist_now[i]) dist_now[i] = sum;
                end
            end
            for (int i = 0; i < n; i++) begin
                word.node = i[5:0];
                word.dval = dist_now[i][12:0];
                word.fin  = (i + 1 == n);
                pending_dist = {pending_dist, word};
            end
        endfunction

        function string check_word(logic [5:0] node, logic [12:0] dv, logic fin);
            dist_word_t exp_word;
            string msg;
            if (pending_dist.size() == 0)
                return $sformatf("unexpected word node=%0d dist=%0d last=%0b", node, dv, fin);
            exp_word = pending_dist.pop_front();
            msg = "";
            if (node !== exp_word.node)
                msg = {msg, $sformatf(" node_index got %0d want %0d", node, exp_word.node)};
            if (dv !== exp_word.dval)
                msg = {msg, $sformatf(" distance got %0d want %0d", dv, exp_word.dval)};
            if (fin !== exp_word.fin)
                msg = {msg, $sformatf(" last got %0b want %0b", fin, exp_word.fin)};
            return msg;
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic                 func;
    logic [5:0]           node_a;
    logic [5:0]           node_b;
    logic [12:0]          edge_weight;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [6:0]           cfg_data;
    logic                 result_valid;
    logic [5:0]           node_index;
    logic [12:0]          distance;
    logic                 last;

    dist_tracker tracker;
    int  fails;
    int  stall_cycles;
    bit  progress;
    bit  idle_on;
    int  random_items;

    shortest_path_dijkstra_solver dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .func(func),
        .node_a(node_a), .node_b(node_b), .edge_weight(edge_weight),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .result_valid(result_valid), .node_index(node_index),
        .distance(distance), .last(last)
    );

    always #2 clk = ~clk;

    task automatic report(input string msg);
        $display("MISMATCH at %0t:%s", $realtime, msg);
        fails++;
    endtask

    // Check each distance word at the rising edge that accepts it, then run the watchdog
    always @(posedge clk)
    begin
        string msg;
        if (rst_n && result_valid === 1'b1) begin
            progress = 1;
            msg = tracker.check_word(node_index, distance, last);
            if (msg != "") report(msg);
        end
        if (progress) stall_cycles = 0;
        else stall_cycles++;
        progress = 0;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog expired at %0t", $realtime);
            $display("Regression FAIL");
            $finish;
        end
    end

    // Drive one item; called at a falling edge, returns at a falling edge
    task automatic put_item(input logic fn, input logic [5:0] a, input logic [5:0] b,
                            input logic [12:0] w);
        if (idle_on && $urandom_range(99) < 19) begin
            start = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        start = 1'b1;
        func = fn;
        node_a = a;
        node_b = b;
        edge_weight = w;
        while (busy !== 1'b0) @(negedge clk);
        @(posedge clk);
        tracker.note_item(fn, a, b, w);
        @(negedge clk);
        progress = 1;
    endtask

    // Hold off until no distance word is pending and the block is quiet
    task automatic wait_idle();
        start = 1'b0;
        while (tracker.pending_dist.size() != 0 || busy !== 1'b0) @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [6:0] data);
        wait_idle();
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        while (cfg_ready !== 1'b1) @(negedge clk);
        @(posedge clk);
        tracker.note_reg(idx, data);
        @(negedge clk);
        progress = 1;
        cfg_valid = 1'b0;
    endtask

    task automatic set_regs(input logic [6:0] count, input logic [5:0] src);
        if ($urandom_range(1)) begin
            write_reg(REG_NODE_COUNT, count);
            write_reg(REG_SOURCE_NODE, {1'b0, src});
        end else begin
            write_reg(REG_SOURCE_NODE, {1'b0, src});
            write_reg(REG_NODE_COUNT, count);
        end
    endtask

    initial
    begin
        int n_cfg;
        int n_eff;
        int span;
        int edges;
        int phase;
        logic [5:0]  a;
        logic [5:0]  b;
        logic [12:0] w;
        logic [5:0]  src;
        logic [6:0]  count;

        tracker = new();
        clk = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        func = FUNC_ADD;
        node_a = '0;
        node_b = '0;
        edge_weight = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_NODE_COUNT;
        cfg_data = '0;
        fails = 0;
        stall_cycles = 0;
        progress = 0;
        idle_on = 1;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        // Directed: field extremes, saturated and oversized weights, parallel edges
        put_item(FUNC_ADD, 6'd0, 6'd63, 13'd0);
        put_item(FUNC_ADD, 6'd63, 6'd1, 13'd4999);
        put_item(FUNC_ADD, 6'd5, 6'd5, 13'd7);
        put_item(FUNC_ADD, 6'd1, 6'd2, 13'd5000);
        put_item(FUNC_ADD, 6'd3, 6'd4, 13'h1FFF);
        put_item(FUNC_ADD, 6'd0, 6'd2, 13'd100);
        put_item(FUNC_ADD, 6'd2, 6'd0, 13'd50);
        put_item(FUNC_ADD, 6'd0, 6'd2, 13'd200);
        put_item(FUNC_ADD, 6'd2, 6'd3, 13'd25);
        put_item(FUNC_ADD, 6'd0, 6'd3, 13'd75);
        put_item(FUNC_ADD, 6'd42, 6'd21, 13'd2730);
        put_item(FUNC_SOLVE, 6'd0, 6'd0, 13'd0);
        // Zero node count acts as one node
        set_regs(7'd0, 6'd0);
        put_item(FUNC_SOLVE, 6'h3F, 6'h3F, 13'h1FFF);
        // Oversized node count saturates; source at the top node
        set_regs(7'h7F, 6'd63);
        put_item(FUNC_SOLVE, 6'd0, 6'd0, 13'd0);
        // Source outside the node range: all unreachable
        set_regs(7'd8, 6'd20);
        put_item(FUNC_SOLVE, 6'd0, 6'd0, 13'd0);
        // Equal distances and a single node
        set_regs(7'd6, 6'd3);
        put_item(FUNC_ADD, 6'd3, 6'd4, 13'd25);
        put_item(FUNC_SOLVE, 6'd0, 6'd0, 13'd0);
        set_regs(7'd1, 6'd0);
        put_item(FUNC_SOLVE, 6'd0, 6'd0, 13'd0);

        // Random phases: registers, a burst of edges, then a solve
        random_items = 0;
        phase = 0;
        while (random_items < 115) begin
            idle_on = !(phase >= 3 && phase <= 5);
            case ($urandom_range(9))
                0: n_cfg = 64;
                1: n_cfg = $urandom_range(1) ? 127 : 0;
                default: n_cfg = $urandom_range(2, 12);
            endcase
            n_eff = (n_cfg == 0) ? 1 : ((n_cfg > 64) ? 64 : n_cfg);
            count = n_cfg[6:0];
            if ($urandom_range(99) < 85) src = 6'($urandom_range(n_eff - 1));
            else src = 6'($urandom_range(63));
            set_regs(count, src);
            edges = $urandom_range(3, 10);
            span = (n_eff + 1 > 63) ? 63 : n_eff + 1;
            repeat (edges) begin
                if ($urandom_range(9) == 0) begin
                    a = 6'($urandom_range(63));
                    b = 6'($urandom_range(63));
                end else begin
                    a = 6'($urandom_range(span));
                    b = 6'($urandom_range(span));
                end
                case ($urandom_range(19))
                    0, 1, 2: w = 13'($urandom_range(8191));
                    3, 4, 5, 6, 7: w = 13'($urandom_range(4999));
                    default: w = 13'($urandom_range(60));
                endcase
                put_item(FUNC_ADD, a, b, w);
                random_items++;
            end
            put_item(FUNC_SOLVE, 6'($urandom_range(63)), 6'($urandom_range(63)),
                     13'($urandom_range(8191)));
            random_items++;
            phase++;
        end

        // Drain and let the block settle
        start = 1'b0;
        while (tracker.pending_dist.size() != 0) @(negedge clk);
        repeat (200) @(negedge clk);
        if (fails == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
